/* hw/rtl/its_pkg.sv */
// Shared types and constants for the indentation test sequencer.
// Used by its_ramp, its_ctrl and indentation_test_sequencer; no dependencies.

package its_pkg;

   // Field widths
   localparam int NOW_W   = 32;
   localparam int FORCE_W = 18;
   localparam int DEPTH_W = 17;
   localparam int TGT_W   = 16;
   localparam int RATE_W  = 16;
   localparam int HOLD_W  = 20;
   localparam int KIND_W  = 2;
   localparam int CSR_AW  = 2;
   localparam int CSR_DW  = 20;
   localparam int REQ_DW  = 72;
   localparam int RSP_DW  = 64;

   // Register reset values
   localparam logic [TGT_W-1:0]  TARGET_RST = 16'd10000;
   localparam logic [RATE_W-1:0] RATE_RST   = 16'd500;
   localparam logic [HOLD_W-1:0] HOLD_RST   = 20'd10000;

   // Thresholds
   localparam int MS_PER_S = 1000;
   localparam logic signed [FORCE_W-1:0] CONTACT_MN     = 18'sd50;
   localparam logic signed [FORCE_W:0]   HOLD_MARGIN_MN = 19'sd5;
   localparam logic signed [FORCE_W-1:0] UNLOAD_END_MN  = 18'sd5;
   localparam logic signed [29:0]        DEADBAND_K     = 30'sd2000;

   typedef enum logic [KIND_W-1:0] {
      KIND_SAMPLE = 2'd0,
      KIND_START  = 2'd1,
      KIND_STOP   = 2'd2
   } kind_type;

   typedef enum logic [CSR_AW-1:0] {
      CSR_TARGET_FORCE = 2'd0,
      CSR_RAMP_RATE    = 2'd1,
      CSR_HOLD_TIME    = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_APPROACH = 3'd1,
      PH_LOAD     = 3'd2,
      PH_HOLD     = 3'd3,
      PH_UNLOAD   = 3'd4,
      PH_RETRACT  = 3'd5,
      PH_ALARM    = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      M_NONE          = 3'd0,
      M_APPROACH      = 3'd1,
      M_STOPHOLD      = 3'd2,
      M_DOWN          = 3'd3,
      M_UP            = 3'd4,
      M_BEGIN_RETRACT = 3'd5,
      M_RETRACT_TICK  = 3'd6,
      M_ESTOP         = 3'd7
   } motor_type;

   typedef enum logic [2:0] {
      EV_NONE         = 3'd0,
      EV_STARTED      = 3'd1,
      EV_REFUSED_TIP  = 3'd2,
      EV_REFUSED_TILT = 3'd3,
      EV_ABORTED      = 3'd4,
      EV_UNLOAD_DONE  = 3'd5,
      EV_RUN_COMPLETE = 3'd6,
      EV_ALARM        = 3'd7
   } event_type;

   // Request payload; last member sits in the lowest bits, matching req_tdata.
   typedef struct packed {
      logic                      level_ok;
      logic                      tip_present;
      logic                      retracted;
      logic                      safety_ok;
      logic signed [DEPTH_W-1:0] sensed_depth;
      logic signed [FORCE_W-1:0] sensed_force;
      logic [NOW_W-1:0]          now_ms;
   } item_type;

   // Result payload; phase in the lowest bits, matching rsp_tdata.
   typedef struct packed {
      logic signed [DEPTH_W-1:0] end_depth;
      logic signed [DEPTH_W-1:0] max_depth;
      logic signed [FORCE_W-1:0] max_force;
      logic [2:0]                event_res;
      logic                      record_point;
      logic [2:0]                motor_cmd;
      logic [2:0]                phase;
   } result_type;

   // Timing state the ramp datapath needs from the controller
   typedef struct packed {
      phase_type                 phase;
      logic [NOW_W-1:0]          contact_time;
      logic [NOW_W-1:0]          unload_start_time;
      logic signed [FORCE_W-1:0] unload_ref_force;
   } ramp_ctx_type;

endpackage

/* hw/rtl/indentation_test_sequencer.sv */
// Indentation test sequencer top level: input register, result register, CSRs.
// Depends on its_pkg and its_ctrl.

// One beat in, one result beat out, one beat per clock sustained while rsp_tready stays
// high. Each item passes an input register, then the phase logic and ramp datapath (one
// 16x32 multiply and deadband compare) combinationally, then the result register, which
// takes the result once the result slot is free. While a result waits, one more request
// is taken into the input register, then req_tready drops until the result leaves. CSR
// writes take effect at the next edge and belong to idle periods.

module indentation_test_sequencer (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // now_ms[31:0], force[49:32], depth[66:50], safety_ok[67], retracted[68],
   // tip_present[69], level_ok[70], zero fill[71]
   input  logic [its_pkg::REQ_DW-1:0]  req_tdata,
   // kind[1:0]
   input  logic [its_pkg::KIND_W-1:0]  req_tuser,
   // result channel
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // phase[2:0], motor_cmd[5:3], record_point[6], event_res[9:7],
   // peak force[27:10], peak depth[44:28], final depth[61:45], zero fill[63:62]
   output logic [its_pkg::RSP_DW-1:0]  rsp_tdata,
   // configuration
   input  logic                        csr_we,
   input  logic [its_pkg::CSR_AW-1:0]  csr_addr,
   input  logic [its_pkg::CSR_DW-1:0]  csr_wdata
);

   logic [its_pkg::TGT_W-1:0]  target_ff;
   logic [its_pkg::RATE_W-1:0] rate_ff;
   logic [its_pkg::HOLD_W-1:0] hold_ff;

   logic                          in_valid_ff, in_valid_in;
   logic [its_pkg::KIND_W-1:0]    in_kind_ff;
   its_pkg::item_type             in_item_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   its_pkg::result_type           rsp_ff;
   its_pkg::result_type           result;
   logic                          req_take;
   logic                          fire;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= its_pkg::TARGET_RST;
         rate_ff   <= its_pkg::RATE_RST;
         hold_ff   <= its_pkg::HOLD_RST;
      end else if (csr_we) begin
         unique case (its_pkg::csr_index_type'(csr_addr))
            its_pkg::CSR_TARGET_FORCE: target_ff <= csr_wdata[its_pkg::TGT_W-1:0];
            its_pkg::CSR_RAMP_RATE:    rate_ff   <= csr_wdata[its_pkg::RATE_W-1:0];
            its_pkg::CSR_HOLD_TIME:    hold_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // the item in the input register moves on when the result slot frees up
   assign fire       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take)  in_valid_in = 1'b1;
      else if (fire) in_valid_in = 1'b0;

      rsp_valid_in = rsp_valid_ff;
      if (fire)            rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_kind_ff <= req_tuser;
         in_item_ff <= req_tdata[$bits(its_pkg::item_type)-1:0];
      end
      if (fire) begin
         rsp_ff <= result;
      end
   end

   its_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .fire               (fire),
      .kind               (its_pkg::kind_type'(in_kind_ff)),
      .item               (in_item_ff),
      .target_force_mn    (target_ff),
      .ramp_rate_mn_per_s (rate_ff),
      .hold_time_ms       (hold_ff),
      .result             (result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(its_pkg::RSP_DW - $bits(its_pkg::result_type)){1'b0}}, rsp_ff};

`ifndef SYNTHESIS
   a_fire_gives_result: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_tvalid)
      else $error("processed beat produced no result");

   // curve points only come from the force-controlled phases or their exits
   a_record_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_ff.record_point) |->
      (rsp_ff.phase == its_pkg::PH_LOAD || rsp_ff.phase == its_pkg::PH_HOLD ||
       rsp_ff.phase == its_pkg::PH_UNLOAD || rsp_ff.phase == its_pkg::PH_RETRACT))
      else $error("record point outside load, hold or unload");

   a_estop_alarm: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
      ((rsp_ff.motor_cmd == its_pkg::M_ESTOP) == (rsp_ff.event_res == its_pkg::EV_ALARM)))
      else $error("emergency stop and alarm event disagree");
`endif

endmodule

/* hw/rtl/its_ramp.sv */
// Expected-force ramp and +/-2 mN deadband compare for load, hold and unload.
// Depends on its_pkg.

module its_ramp (
   input  its_pkg::ramp_ctx_type               ctx,
   input  logic [its_pkg::NOW_W-1:0]           now_ms,
   input  logic signed [its_pkg::FORCE_W-1:0]  sensed_force,
   input  logic [its_pkg::TGT_W-1:0]           target_force_mn,
   input  logic [its_pkg::RATE_W-1:0]          ramp_rate_mn_per_s,
   output its_pkg::motor_type                  db_cmd
);

   logic [its_pkg::NOW_W-1:0] start_time;
   logic [its_pkg::NOW_W-1:0] elapsed;
   logic [47:0]               prod;
   logic [25:0]               cap;
   logic signed [27:0]        usf_k;
   logic [26:0]               e_load;
   logic [26:0]               e_unload;
   logic [26:0]               expect_k;
   logic signed [29:0]        expect_s;
   logic signed [29:0]        force_k;

   // One shared multiplier: elapsed time since contact or since unload start
   assign start_time = (ctx.phase == its_pkg::PH_LOAD) ? ctx.contact_time
                                                       : ctx.unload_start_time;
   assign elapsed    = now_ms - start_time;
   assign prod       = 48'(ramp_rate_mn_per_s) * 48'(elapsed);

   assign cap   = 26'(target_force_mn) * 26'(its_pkg::MS_PER_S);
   assign usf_k = $signed({{10{ctx.unload_ref_force[its_pkg::FORCE_W-1]}},
                           ctx.unload_ref_force}) * $signed(28'(its_pkg::MS_PER_S));

   assign e_load = (prod > {22'b0, cap}) ? {1'b0, cap} : prod[26:0];

   always_comb begin
      if (usf_k <= 28'sd0 || prod >= {20'b0, usf_k}) begin
         e_unload = '0;
      end else begin
         e_unload = usf_k[26:0] - prod[26:0];
      end
   end

   always_comb begin
      case (ctx.phase)
         its_pkg::PH_LOAD:   expect_k = e_load;
         its_pkg::PH_UNLOAD: expect_k = e_unload;
         default:            expect_k = {1'b0, cap};
      endcase
   end

   assign expect_s = $signed({3'b0, expect_k});
   assign force_k  = $signed({{12{sensed_force[its_pkg::FORCE_W-1]}}, sensed_force})
                     * $signed(30'(its_pkg::MS_PER_S));

   always_comb begin
      if (expect_s > force_k + its_pkg::DEADBAND_K) begin
         db_cmd = its_pkg::M_DOWN;
      end else if (expect_s < force_k - its_pkg::DEADBAND_K) begin
         db_cmd = its_pkg::M_UP;
      end else begin
         db_cmd = its_pkg::M_NONE;
      end
   end

endmodule

/* hw/rtl/its_ctrl.sv */
// Phase state machine, run timestamps and peak tracking; builds one result per beat.
// Depends on its_pkg and its_ramp.

module its_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       fire,
   input  its_pkg::kind_type          kind,
   input  its_pkg::item_type          item,
   input  logic [its_pkg::TGT_W-1:0]  target_force_mn,
   input  logic [its_pkg::RATE_W-1:0] ramp_rate_mn_per_s,
   input  logic [its_pkg::HOLD_W-1:0] hold_time_ms,
   output its_pkg::result_type        result
);

   its_pkg::phase_type phase_ff, phase_in;
   logic [its_pkg::NOW_W-1:0] contact_time_ff, contact_time_in;
   logic [its_pkg::NOW_W-1:0] hold_start_ff, hold_start_in;
   logic [its_pkg::NOW_W-1:0] unload_start_ff, unload_start_in;
   logic signed [its_pkg::FORCE_W-1:0] usf_ff, usf_in;
   logic signed [its_pkg::FORCE_W-1:0] peak_force_ff, peak_force_in;
   logic signed [its_pkg::DEPTH_W-1:0] peak_depth_ff, peak_depth_in;
   logic signed [its_pkg::DEPTH_W-1:0] final_depth_ff, final_depth_in;

   its_pkg::ramp_ctx_type ctx;
   its_pkg::motor_type    db_cmd;
   its_pkg::motor_type    motor;
   its_pkg::event_type    ev;
   logic                  rec;
   logic signed [its_pkg::FORCE_W:0] hold_thr;
   logic [its_pkg::NOW_W-1:0] hold_age;

   assign ctx.phase             = phase_ff;
   assign ctx.contact_time      = contact_time_ff;
   assign ctx.unload_start_time = unload_start_ff;
   assign ctx.unload_ref_force  = usf_ff;

   its_ramp u_ramp (
      .ctx                (ctx),
      .now_ms             (item.now_ms),
      .sensed_force       (item.sensed_force),
      .target_force_mn    (target_force_mn),
      .ramp_rate_mn_per_s (ramp_rate_mn_per_s),
      .db_cmd             (db_cmd)
   );

   assign hold_thr = $signed({3'b0, target_force_mn}) - its_pkg::HOLD_MARGIN_MN;
   assign hold_age = item.now_ms - hold_start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= its_pkg::PH_IDLE;
         contact_time_ff <= '0;
         hold_start_ff   <= '0;
         unload_start_ff <= '0;
         usf_ff          <= '0;
         peak_force_ff   <= '0;
         peak_depth_ff   <= '0;
         final_depth_ff  <= '0;
      end else if (fire) begin
         phase_ff        <= phase_in;
         contact_time_ff <= contact_time_in;
         hold_start_ff   <= hold_start_in;
         unload_start_ff <= unload_start_in;
         usf_ff          <= usf_in;
         peak_force_ff   <= peak_force_in;
         peak_depth_ff   <= peak_depth_in;
         final_depth_ff  <= final_depth_in;
      end
   end

   always_comb begin
      phase_in        = phase_ff;
      contact_time_in = contact_time_ff;
      hold_start_in   = hold_start_ff;
      unload_start_in = unload_start_ff;
      usf_in          = usf_ff;
      peak_force_in   = peak_force_ff;
      peak_depth_in   = peak_depth_ff;
      final_depth_in  = final_depth_ff;
      motor           = its_pkg::M_NONE;
      ev              = its_pkg::EV_NONE;
      rec             = 1'b0;

      unique case (kind)
         its_pkg::KIND_SAMPLE: begin
            // peaks track every sample, even in idle and alarm
            if (item.sensed_force > peak_force_ff) peak_force_in = item.sensed_force;
            if (item.sensed_depth > peak_depth_ff) peak_depth_in = item.sensed_depth;
            if (!item.safety_ok) begin
               phase_in = its_pkg::PH_ALARM;
               motor    = its_pkg::M_ESTOP;
               ev       = its_pkg::EV_ALARM;
            end else begin
               unique case (phase_ff)
                  its_pkg::PH_APPROACH: begin
                     if (item.sensed_force > its_pkg::CONTACT_MN) begin
                        motor           = its_pkg::M_STOPHOLD;
                        phase_in        = its_pkg::PH_LOAD;
                        contact_time_in = item.now_ms;
                        peak_force_in   = item.sensed_force;
                        peak_depth_in   = item.sensed_depth;
                     end else begin
                        motor = its_pkg::M_APPROACH;
                     end
                  end
                  its_pkg::PH_LOAD: begin
                     motor = db_cmd;
                     rec   = 1'b1;
                     if ($signed({item.sensed_force[its_pkg::FORCE_W-1], item.sensed_force})
                         >= hold_thr) begin
                        phase_in      = its_pkg::PH_HOLD;
                        hold_start_in = item.now_ms;
                        peak_force_in = item.sensed_force;
                        peak_depth_in = item.sensed_depth;
                     end
                  end
                  its_pkg::PH_HOLD: begin
                     motor = db_cmd;
                     rec   = 1'b1;
                     if (hold_age >= {12'b0, hold_time_ms}) begin
                        phase_in        = its_pkg::PH_UNLOAD;
                        unload_start_in = item.now_ms;
                        usf_in          = item.sensed_force;
                     end
                  end
                  its_pkg::PH_UNLOAD: begin
                     motor = db_cmd;
                     rec   = 1'b1;
                     // end of unload overrides the deadband command
                     if (item.sensed_force < its_pkg::UNLOAD_END_MN) begin
                        final_depth_in = item.sensed_depth;
                        motor          = its_pkg::M_BEGIN_RETRACT;
                        phase_in       = its_pkg::PH_RETRACT;
                        ev             = its_pkg::EV_UNLOAD_DONE;
                     end
                  end
                  its_pkg::PH_RETRACT: begin
                     motor = its_pkg::M_RETRACT_TICK;
                     if (item.retracted) begin
                        phase_in = its_pkg::PH_IDLE;
                        ev       = its_pkg::EV_RUN_COMPLETE;
                     end
                  end
                  default: ;
               endcase
            end
         end
         its_pkg::KIND_START: begin
            if (phase_ff == its_pkg::PH_IDLE) begin
               if (!item.tip_present) begin
                  ev = its_pkg::EV_REFUSED_TIP;
               end else if (!item.level_ok) begin
                  ev = its_pkg::EV_REFUSED_TILT;
               end else begin
                  motor    = its_pkg::M_APPROACH;
                  phase_in = its_pkg::PH_APPROACH;
                  ev       = its_pkg::EV_STARTED;
               end
            end
         end
         its_pkg::KIND_STOP: begin
            if (phase_ff == its_pkg::PH_LOAD || phase_ff == its_pkg::PH_HOLD ||
                phase_ff == its_pkg::PH_UNLOAD) begin
               motor    = its_pkg::M_BEGIN_RETRACT;
               phase_in = its_pkg::PH_RETRACT;
               ev       = its_pkg::EV_ABORTED;
            end
         end
         default: ;
      endcase
   end

   assign result.phase        = phase_in;
   assign result.motor_cmd    = motor;
   assign result.record_point = rec;
   assign result.event_res    = ev;
   assign result.max_force    = peak_force_in;
   assign result.max_depth    = peak_depth_in;
   assign result.end_depth    = final_depth_in;

`ifndef SYNTHESIS
   // alarm is left only through reset
   a_alarm_sticky: assert property (@(posedge clock) disable iff (reset)
      phase_ff == its_pkg::PH_ALARM |=> phase_ff == its_pkg::PH_ALARM)
      else $error("alarm phase was left without reset");

   // idle exits only into approach (start) or alarm (fault)
   a_idle_exit: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == its_pkg::PH_IDLE && phase_in != its_pkg::PH_IDLE) |->
      (phase_in == its_pkg::PH_APPROACH || phase_in == its_pkg::PH_ALARM))
      else $error("illegal exit from idle");

   // curve points come only from the force-controlled phases
   a_record_src: assert property (@(posedge clock) disable iff (reset)
      (fire && rec) |->
      (phase_ff == its_pkg::PH_LOAD || phase_ff == its_pkg::PH_HOLD ||
       phase_ff == its_pkg::PH_UNLOAD))
      else $error("record point from outside load, hold or unload");
`endif

endmodule

/* test/tb.sv */
// Self-checking bench for the indentation test sequencer: drives whole test runs as
// request beats, predicts each result beat in step and compares it field by field.
// Depends on its_pkg and indentation_test_sequencer.

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import its_pkg::*;

   localparam int     LIMIT_CYCLES    = 200000;
   localparam int     SETTLE_CYCLES   = 4;
   localparam int     HOLD_OFF_CYCLES = 120;
   localparam int     CONTACT_FORCE   = 50;
   localparam int     HOLD_MARGIN     = 5;
   localparam int     UNLOAD_END      = 5;
   localparam longint BAND            = 2000;
   localparam longint MILLI           = 1000;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_DW-1:0] req_tdata  = '0;
   logic [KIND_W-1:0] req_tuser  = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_DW-1:0] rsp_tdata;
   logic              csr_we     = 1'b0;
   logic [CSR_AW-1:0] csr_addr   = '0;
   logic [CSR_DW-1:0] csr_wdata  = '0;

   indentation_test_sequencer dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor copy of the settings and the sequencer state
   logic [TGT_W-1:0]           cfg_target = 16'd10000;
   logic [RATE_W-1:0]          cfg_rate   = 16'd500;
   logic [HOLD_W-1:0]          cfg_hold   = 20'd10000;
   phase_type                  ph         = PH_IDLE;
   logic [NOW_W-1:0]           t_start    = '0;
   logic [NOW_W-1:0]           t_contact  = '0;
   logic [NOW_W-1:0]           t_hold     = '0;
   logic [NOW_W-1:0]           t_unload   = '0;
   logic signed [FORCE_W-1:0]  unload_from = '0;
   logic signed [FORCE_W-1:0]  top_force  = '0;
   logic signed [DEPTH_W-1:0]  top_depth  = '0;
   logic signed [DEPTH_W-1:0]  rest_depth = '0;

   result_type       pending_results[$];
   logic [NOW_W-1:0] stamp = '0;
   int               errors = 0;
   int               beats_sent = 0;
   int               results_checked = 0;
   int               runs_completed = 0;
   int               runs_aborted = 0;
   int               cycle_count = 0;
   int               send_idle_pct = 15;
   int               stall_pct = 15;
   int               hold_req = 0;
   int               hold_seen = 0;
   int               hold_left = 0;

   function automatic motor_type band_cmd(longint want, logic signed [FORCE_W-1:0] f);
      longint scaled;
      scaled = longint'(f) * MILLI;
      if (want > scaled + BAND) return M_DOWN;
      if (want < scaled - BAND) return M_UP;
      return M_NONE;
   endfunction

   // expected force x1000 while loading
   function automatic longint load_curve(logic [NOW_W-1:0] now);
      logic [NOW_W-1:0] elapsed;
      longint want, cap;
      elapsed = now - t_contact;
      want = longint'({32'd0, elapsed}) * longint'({48'd0, cfg_rate});
      cap = longint'({48'd0, cfg_target}) * MILLI;
      return (want > cap) ? cap : want;
   endfunction

   // expected force x1000 while unloading, floored at zero
   function automatic longint unload_curve(logic [NOW_W-1:0] now);
      logic [NOW_W-1:0] elapsed;
      longint want;
      elapsed = now - t_unload;
      want = longint'(unload_from) * MILLI
           - longint'({32'd0, elapsed}) * longint'({48'd0, cfg_rate});
      return (want < 0) ? 0 : want;
   endfunction

   function automatic result_type advance_sequencer(kind_type k, item_type it);
      result_type       r;
      motor_type        motor;
      event_type        ev;
      logic             rec;
      logic [NOW_W-1:0] held;
      motor = M_NONE;
      ev    = EV_NONE;
      rec   = 1'b0;
      case (k)
         KIND_SAMPLE: begin
            if (it.sensed_force > top_force) top_force = it.sensed_force;
            if (it.sensed_depth > top_depth) top_depth = it.sensed_depth;
            if (!it.safety_ok) begin
               ph    = PH_ALARM;
               motor = M_ESTOP;
               ev    = EV_ALARM;
            end else begin
               case (ph)
                  PH_APPROACH: begin
                     if (int'(it.sensed_force) > CONTACT_FORCE) begin
                        motor     = M_STOPHOLD;
                        ph        = PH_LOAD;
                        t_contact = it.now_ms;
                        top_force = it.sensed_force;
                        top_depth = it.sensed_depth;
                     end else begin
                        motor = M_APPROACH;
                     end
                  end
                  PH_LOAD: begin
                     motor = band_cmd(load_curve(it.now_ms), it.sensed_force);
                     rec   = 1'b1;
                     if (int'(it.sensed_force) >= int'(cfg_target) - HOLD_MARGIN) begin
                        ph        = PH_HOLD;
                        t_hold    = it.now_ms;
                        top_force = it.sensed_force;
                        top_depth = it.sensed_depth;
                     end
                  end
                  PH_HOLD: begin
                     motor = band_cmd(longint'({48'd0, cfg_target}) * MILLI, it.sensed_force);
                     rec   = 1'b1;
                     held  = it.now_ms - t_hold;
                     if (held >= {12'd0, cfg_hold}) begin
                        ph          = PH_UNLOAD;
                        t_unload    = it.now_ms;
                        unload_from = it.sensed_force;
                     end
                  end
                  PH_UNLOAD: begin
                     motor = band_cmd(unload_curve(it.now_ms), it.sensed_force);
                     rec   = 1'b1;
                     if (int'(it.sensed_force) < UNLOAD_END) begin
                        rest_depth = it.sensed_depth;
                        motor      = M_BEGIN_RETRACT;
                        ph         = PH_RETRACT;
                        ev         = EV_UNLOAD_DONE;
                     end
                  end
                  PH_RETRACT: begin
                     motor = M_RETRACT_TICK;
                     if (it.retracted) begin
                        ph = PH_IDLE;
                        ev = EV_RUN_COMPLETE;
                        runs_completed++;
                     end
                  end
                  default: ;
               endcase
            end
         end
         KIND_START: begin
            if (ph == PH_IDLE) begin
               if (!it.tip_present) begin
                  ev = EV_REFUSED_TIP;
               end else if (!it.level_ok) begin
                  ev = EV_REFUSED_TILT;
               end else begin
                  motor   = M_APPROACH;
                  ph      = PH_APPROACH;
                  t_start = it.now_ms;
                  ev      = EV_STARTED;
               end
            end
         end
         KIND_STOP: begin
            if (ph == PH_LOAD || ph == PH_HOLD || ph == PH_UNLOAD) begin
               motor = M_BEGIN_RETRACT;
               ph    = PH_RETRACT;
               ev    = EV_ABORTED;
               runs_aborted++;
            end
         end
         default: ;
      endcase
      r.phase        = ph;
      r.motor_cmd    = motor;
      r.record_point = rec;
      r.event_res    = ev;
      r.max_force    = top_force;
      r.max_depth    = top_depth;
      r.end_depth    = rest_depth;
      return r;
   endfunction

   // ---------------------------------------------------------------- driving

   task automatic send_beat(kind_type k, item_type it);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, it};
      req_tuser  <= k;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(advance_sequencer(k, it));
      beats_sent++;
   endtask

   function automatic item_type fresh_item();
      item_type it;
      it.now_ms       = stamp;
      it.sensed_force = FORCE_W'($urandom);
      it.sensed_depth = DEPTH_W'($urandom);
      it.safety_ok    = 1'b1;
      it.retracted    = 1'($urandom_range(0, 1));
      it.tip_present  = 1'($urandom_range(0, 1));
      it.level_ok     = 1'($urandom_range(0, 1));
      return it;
   endfunction

   task automatic send_sample(int f, int d, logic retr);
      item_type it;
      it = fresh_item();
      it.sensed_force = FORCE_W'(f);
      it.sensed_depth = DEPTH_W'(d);
      it.retracted    = retr;
      send_beat(KIND_SAMPLE, it);
   endtask

   task automatic send_press(kind_type k, logic tip, logic lvl);
      item_type it;
      it = fresh_item();
      it.tip_present = tip;
      it.level_ok    = lvl;
      send_beat(k, it);
   endtask

   function automatic int jitter();
      return int'($urandom_range(0, 8)) - 4;
   endfunction

   function automatic int rand_depth();
      if ($urandom_range(0, 9) == 0) return int'($urandom_range(0, 131071)) - 65536;
      return int'($urandom_range(0, 4000)) - 200;
   endfunction

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DW-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_TARGET_FORCE: cfg_target = value[TGT_W-1:0];
         CSR_RAMP_RATE:    cfg_rate   = value[RATE_W-1:0];
         CSR_HOLD_TIME:    cfg_hold   = value;
         default: ;
      endcase
   endtask

   task automatic apply_settings(int unsigned tgt, int unsigned rate, int unsigned hold);
      wait_drained();
      write_reg(CSR_TARGET_FORCE, tgt);
      write_reg(CSR_RAMP_RATE, rate);
      write_reg(CSR_HOLD_TIME, hold);
      csr_we <= 1'b0;
   endtask

   // One test run from idle back to idle, steered by the predicted phase so that
   // most beats land in the deeper phases; stray presses mixed in.
   task automatic random_run();
      int        steps, in_phase, span, roll, f;
      phase_type seen;
      repeat ($urandom_range(0, 2)) begin
         stamp += $urandom_range(1, 50);
         case ($urandom_range(0, 3))
            0: send_sample(int'($urandom_range(0, 262143)) - 131072, rand_depth(),
                           $urandom_range(0, 1));
            1: send_press(KIND_STOP, $urandom_range(0, 1), $urandom_range(0, 1));
            2: send_press(KIND_START, 1'b0, $urandom_range(0, 1));
            default: send_press(KIND_START, 1'b1, 1'b0);
         endcase
      end
      stamp += $urandom_range(1, 50);
      send_press(KIND_START, 1'b1, 1'b1);
      steps    = 0;
      in_phase = 0;
      seen     = ph;
      span     = $urandom_range(1, 8);
      while (ph != PH_IDLE && ph != PH_ALARM && steps < 60) begin
         steps++;
         if (ph != seen) begin
            seen     = ph;
            in_phase = 0;
            span     = $urandom_range(1, 8);
         end
         in_phase++;
         stamp += $urandom_range(1, 40);
         roll = $urandom_range(0, 99);
         if (roll < 2) begin
            send_press(KIND_STOP, $urandom_range(0, 1), $urandom_range(0, 1));
         end else if (roll < 4) begin
            send_press(KIND_START, $urandom_range(0, 1), $urandom_range(0, 1));
         end else begin
            case (ph)
               PH_APPROACH: begin
                  if (in_phase > span) f = $urandom_range(51, 400);
                  else f = int'($urandom_range(0, 150)) - 100;
                  send_sample(f, rand_depth(), 1'b0);
               end
               PH_LOAD: begin
                  stamp += $urandom_range(1, 1500);
                  if (in_phase <= span) f = int'(load_curve(stamp) / MILLI) + jitter();
                  else if ($urandom_range(0, 3) == 0) f = cfg_target + $urandom_range(0, 50);
                  else f = int'(cfg_target) - int'($urandom_range(0, 5));
                  send_sample(f, rand_depth(), 1'b0);
               end
               PH_HOLD: begin
                  if (in_phase > span) stamp = t_hold + {12'd0, cfg_hold} + $urandom_range(0, 3);
                  send_sample(int'(cfg_target) + jitter(), rand_depth(), 1'b0);
               end
               PH_UNLOAD: begin
                  stamp += $urandom_range(1, 1500);
                  if (in_phase > span) f = 4 - int'($urandom_range(0, 30));
                  else f = int'(unload_curve(stamp) / MILLI) + jitter();
                  send_sample(f, rand_depth(), 1'b0);
               end
               PH_RETRACT: begin
                  send_sample(int'($urandom_range(0, 40)) - 20, rand_depth(),
                              in_phase > 3 || $urandom_range(0, 2) == 0);
               end
               default: ;
            endcase
         end
      end
      // bring a long run home
      while (ph != PH_IDLE && ph != PH_ALARM) begin
         stamp += 1;
         case (ph)
            PH_APPROACH: send_sample(100, rand_depth(), 1'b0);
            PH_RETRACT:  send_sample(0, rand_depth(), 1'b1);
            default:     send_press(KIND_STOP, 1'b1, 1'b1);
         endcase
      end
   endtask

   task automatic run_beats(int n);
      int goal;
      goal = beats_sent + n;
      while (beats_sent < goal) random_run();
   endtask

   // ------------------------------------------------------------------ tests

   // field extremes, every press outcome, and each phase boundary at reset settings
   task automatic test_directed();
      logic [NOW_W-1:0] c;
      stamp = 32'hFFFF_FC00;
      send_sample(131071, 65535, 1'b0);
      send_sample(-131072, -65536, 1'b0);
      send_press(KIND_STOP, 1'b1, 1'b1);
      send_press(KIND_START, 1'b0, 1'b1);
      send_press(KIND_START, 1'b1, 1'b0);
      send_press(KIND_START, 1'b1, 1'b1);
      send_press(KIND_START, 1'b1, 1'b1);
      send_press(KIND_STOP, 1'b1, 1'b1);
      send_sample(50, 10, 1'b0);
      send_sample(51, 12, 1'b0);
      c = stamp;
      // ramp elapsed crosses the time stamp wrap here
      stamp = c + 32'd4000;
      send_sample(2000, 100, 1'b0);
      send_sample(1997, 101, 1'b0);
      send_sample(2003, 102, 1'b0);
      send_sample(1998, 99, 1'b0);
      stamp = c + 32'd100000;
      send_sample(9995, 300, 1'b0);
      c = stamp;
      stamp = c + 32'd9999;
      send_sample(10000, 310, 1'b0);
      stamp = c + 32'd10000;
      send_sample(9990, 305, 1'b0);
      c = stamp;
      stamp = c + 32'd1000;
      send_sample(9490, 200, 1'b0);
      stamp = c + 32'd30000;
      send_sample(5, 20, 1'b0);
      send_sample(4, 18, 1'b0);
      send_sample(-3, 5, 1'b0);
      send_sample(-3, 4, 1'b1);
      stamp += 7;
      send_press(KIND_START, 1'b1, 1'b1);
      send_sample(1000, 50, 1'b0);
      send_press(KIND_STOP, 1'b1, 1'b1);
      send_sample(0, 0, 1'b1);
   endtask

   task automatic test_streaming();
      wait_drained();
      send_idle_pct = 0;
      stall_pct <= 0;
      run_beats(80);
      wait_drained();
      send_idle_pct = 15;
      stall_pct <= 15;
   endtask

   task automatic test_backpressure();
      wait_drained();
      send_idle_pct = 0;
      hold_req <= hold_req + 1;
      run_beats(40);
      wait_drained();
      send_idle_pct = 15;
   endtask

   task automatic test_settings_sweep();
      apply_settings(50000, 50000, 600000);
      run_beats(120);
      apply_settings(0, 0, 0);
      run_beats(100);
      apply_settings(50000, 1, 1);
      run_beats(80);
      apply_settings(1, 50000, 600000);
      run_beats(80);
      repeat (3) begin
         apply_settings($urandom_range(0, 50000), $urandom_range(0, 50000),
                        $urandom_range(0, 600000));
         run_beats(70);
      end
   endtask

   // alarm is sticky until reset, so this comes last
   task automatic test_safety_alarm();
      item_type it;
      wait_drained();
      stamp += 10;
      send_press(KIND_START, 1'b1, 1'b1);
      stamp += 10;
      send_sample(120, 40, 1'b0);
      stamp += 200;
      send_sample(int'(load_curve(stamp) / MILLI), 60, 1'b0);
      it = fresh_item();
      it.safety_ok = 1'b0;
      send_beat(KIND_SAMPLE, it);
      repeat (2) begin
         stamp += 5;
         send_sample(int'($urandom_range(0, 262143)) - 131072, rand_depth(), 1'b1);
      end
      send_press(KIND_START, 1'b1, 1'b1);
      send_press(KIND_STOP, 1'b1, 1'b1);
      it = fresh_item();
      it.safety_ok = 1'b0;
      send_beat(KIND_SAMPLE, it);
      send_sample(0, 0, 1'b1);
   endtask

   // --------------------------------------------------------------- receiving

   always @(posedge clock) begin
      if (hold_seen != hold_req) begin
         hold_seen  <= hold_req;
         hold_left  <= HOLD_OFF_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   task automatic check_field(string name, longint want, longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = result_type'(rsp_tdata[$bits(result_type)-1:0]);
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, actual %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            check_field("phase", want.phase, got.phase);
            check_field("motor_cmd", want.motor_cmd, got.motor_cmd);
            check_field("record_point", want.record_point, got.record_point);
            check_field("event_res", want.event_res, got.event_res);
            check_field("peak force", $signed(want.max_force), $signed(got.max_force));
            check_field("peak depth", $signed(want.max_depth), $signed(got.max_depth));
            check_field("final depth", $signed(want.end_depth), $signed(got.end_depth));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("%0t: timed out with %0d results outstanding", $time, pending_results.size());
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_streaming();
      test_backpressure();
      test_settings_sweep();
      test_safety_alarm();
      wait_drained();
      $display("Sent %0d request beats, checked %0d results: %0d runs completed, %0d aborted.",
               beats_sent, results_checked, runs_completed, runs_aborted);
      $display("Settings swept to both ends, result stall and sticky alarm exercised.");
      if (errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
